### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define DDO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, reset-qualified.
`define DDO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hdl/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPM = 2'd0,
    REG_CPR = 2'd1,
    REG_MAX_SPEED = 2'd2,
    REG_COV = 2'd3
  } cfg_reg_e;

  localparam logic [19:0] CPM_RESET  = 20'd1000;
  localparam logic [19:0] CPR_RESET  = 20'd1000;
  localparam logic [15:0] MS_RESET   = 16'd2000;
  localparam logic [31:0] COV_RESET  = 32'd65536;

  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314856;
  localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] JUMP_SCALE = 32'd2000000000;
  localparam logic [31:0] RATE_MULT  = 32'd15625;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);

  // divider geometry
  localparam int DIV_REM_W  = 46;
  localparam int DIV_BITS_W = 77;
  localparam int DIV_CNT_W  = 7;
  localparam int DIV_Q_W    = 32;

  typedef struct packed {
    logic [DIV_REM_W-1:0]  den;
    logic [DIV_REM_W-1:0]  rem0;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_CNT_W-1:0]  steps;
    logic                  modular;
  } div_cmd_t;

  function automatic logic signed [33:0] atan_q29(input logic [CORDIC_CNT_W-1:0] i);
    logic signed [33:0] r;
    unique case (i)
      0: r = 34'sd421657428;
      1: r = 34'sd248918915;
      2: r = 34'sd131521918;
      3: r = 34'sd66762579;
      4: r = 34'sd33510843;
      5: r = 34'sd16771758;
      6: r = 34'sd8387925;
      7: r = 34'sd4194219;
      8: r = 34'sd2097141;
      9: r = 34'sd1048575;
      default: r = 34'sd1 <<< (34'd29 - 34'(i));
    endcase
    return r;
  endfunction

endpackage

### hdl/ddo_if.sv
`timescale 1ns / 1ps
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] right_count;
  logic signed [47:0] left_count;
  logic        [23:0] elapsed_us;

  modport source (output valid, right_count, left_count, elapsed_us, input ready);
  modport sink (input valid, right_count, left_count, elapsed_us, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] pos_x;
  logic signed [39:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] linear_velocity;
  logic signed [31:0] yaw_rate;
  logic        [31:0] covariance_out;
  logic               jump_detected;

  modport source (output valid, pos_x, pos_y, heading, linear_velocity, yaw_rate,
                  covariance_out, jump_detected, input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_velocity, yaw_rate,
                covariance_out, jump_detected, output ready);
endinterface

### hdl/diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
// Differential-drive wheel odometry. One sample (absolute wheel counts and elapsed
// microseconds) is taken at a time; in_if.ready is low from acceptance until the
// result is loaded into the output register, which then waits for out_if.ready
// while the next sample may already be taken. A normal sample runs ten wide
// products on one 32x32 multiplier, four passes of a one-bit-per-cycle divider
// (32, 32, 77 and 32 steps, the heading increment being the long one) and 24
// CORDIC iterations. A jump or zero-time sample finishes after the jump check.
// A new result waits in the done state while the previous one is not yet taken.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the block is idle; the block itself does
// not enforce this.
module diff_drive_odometry_unit import ddo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ddo_in_if.sink                in_if,
  ddo_out_if.source             out_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV_GO, S_DIV_WAIT, S_YAW, S_COR_GO, S_COR_WAIT, S_DONE
  } state_e;

  state_e state_q;
  logic [3:0] k_q;
  logic [1:0] ph_q;
  logic [1:0] j_q;
  logic       jump_q;

  logic [19:0] cpm_q, cpr_q;
  logic [15:0] ms_q;
  logic [31:0] cov_q;

  logic [47:0] last_r_q, last_l_q;
  logic [39:0] acc_x_q, acc_y_q;
  logic [31:0] acc_yaw_q;

  // per-sample datapath
  logic [23:0] el_q;
  logic [47:0] mdr_q, mdl_q;
  logic [48:0] msum_q, mdiff_q;
  logic        sneg_q, dneg_q;
  logic [39:0] p1_q;
  logic [61:0] plim_q;
  logic        jr_q;
  logic [43:0] den_v_q, den_r_q;
  logic [62:0] nv_q, nr_q;
  logic [63:0] prod_lo_q;
  logic [31:0] lv_q, yr_q, yawq_q, dq_q, yaw_new_q;
  logic [31:0] cmag_q, smag_q;
  logic        cneg_q, sinneg_q;
  logic [63:0] xmag_q, ymag_q;

  // output register
  logic        out_valid_q;
  logic [39:0] o_x_q, o_y_q;
  logic [31:0] o_yaw_q, o_lv_q, o_yr_q, o_cov_q;
  logic        o_jump_q;

  logic [19:0] cpm_eff, cpr_eff;
  logic [21:0] cpm3;
  logic [63:0] op_a;
  logic [31:0] op_b, mul_a;
  logic [63:0] mul_p;
  logic [95:0] full;
  logic        in_acc, out_free;

  logic [47:0] dr, dl;
  logic [48:0] sum, diff;

  div_cmd_t    div_cmd;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        ovf_v, ovf_r, ovf_d;

  logic        cor_start, cor_done;
  logic signed [31:0] cor_cos, cor_sin;

  logic [31:0]        qadj;
  logic signed [33:0] ysum, yw;

  logic [64:0] xp, yp;
  logic [34:0] xstep, ystep;
  logic [39:0] acc_x_d, acc_y_d;

  assign cpm_eff = (cpm_q == '0) ? 20'd1 : cpm_q;
  assign cpr_eff = (cpr_q == '0) ? 20'd1 : cpr_q;
  assign cpm3    = {2'b0, cpm_eff} + {1'b0, cpm_eff, 1'b0};

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  assign dr   = in_if.right_count - last_r_q;
  assign dl   = in_if.left_count - last_l_q;
  assign sum  = {dr[47], dr} + {dl[47], dl};
  assign diff = {dr[47], dr} - {dl[47], dl};

  // product table for the shared multiplier
  always_comb begin
    unique case (k_q)
      4'd0: begin op_a = 64'(el_q);   op_b = 32'(ms_q);    end
      4'd1: begin op_a = 64'(p1_q);   op_b = 32'(cpm3);    end
      4'd2: begin op_a = 64'(mdr_q);  op_b = JUMP_SCALE;   end
      4'd3: begin op_a = 64'(mdl_q);  op_b = JUMP_SCALE;   end
      4'd4: begin op_a = 64'(el_q);   op_b = 32'(cpm_eff); end
      4'd5: begin op_a = 64'(el_q);   op_b = 32'(cpr_eff); end
      4'd6: begin op_a = 64'(msum_q); op_b = RATE_MULT;    end
      4'd7: begin op_a = 64'(mdiff_q); op_b = RATE_MULT;   end
      4'd8: begin op_a = 64'(dq_q);   op_b = cmag_q;       end
      4'd9: begin op_a = 64'(dq_q);   op_b = smag_q;       end
      default: begin op_a = '0; op_b = '0; end
    endcase
    mul_a    = (ph_q == 2'd0) ? op_a[31:0] : op_a[63:32];
    full     = {32'b0, prod_lo_q} + {mul_p, 32'b0};
  end

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (op_b),
    .p_o   (mul_p)
  );

  // overflow prechecks: quotient would reach 2^32
  assign ovf_v = nv_q[62:11] >= {8'b0, den_v_q};
  assign ovf_r = nr_q[62:11] >= {8'b0, den_r_q};
  assign ovf_d = msum_q[48:17] >= {12'b0, cpm_eff};

  always_comb begin
    unique case (j_q)
      2'd0: begin
        div_cmd.den     = {2'b0, den_v_q};
        div_cmd.rem0    = nv_q[56:11];
        div_cmd.bits    = {nv_q[10:0], 66'b0};
        div_cmd.steps   = DIV_CNT_W'(32);
        div_cmd.modular = 1'b0;
      end
      2'd1: begin
        div_cmd.den     = {2'b0, den_r_q};
        div_cmd.rem0    = nr_q[56:11];
        div_cmd.bits    = {nr_q[10:0], 66'b0};
        div_cmd.steps   = DIV_CNT_W'(32);
        div_cmd.modular = 1'b0;
      end
      2'd2: begin
        div_cmd.den     = {26'b0, cpr_eff};
        div_cmd.rem0    = '0;
        div_cmd.bits    = {mdiff_q, 28'b0};
        div_cmd.steps   = DIV_CNT_W'(DIV_BITS_W);
        div_cmd.modular = 1'b1;
      end
      default: begin
        div_cmd.den     = {26'b0, cpm_eff};
        div_cmd.rem0    = {14'b0, msum_q[48:17]};
        div_cmd.bits    = {msum_q[16:0], 60'b0};
        div_cmd.steps   = DIV_CNT_W'(32);
        div_cmd.modular = 1'b0;
      end
    endcase
  end

  assign div_start = (state_q == S_DIV_GO);

  ddo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cmd_i   (div_cmd),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign cor_start = (state_q == S_COR_GO);

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (yaw_new_q),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  function automatic logic [31:0] sat_rate(input logic neg, input logic ovf,
                                           input logic [31:0] q);
    logic [31:0] qc;
    qc = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
    if (neg) begin
      return 32'(-qc);
    end
    return (qc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qc;
  endfunction

  // heading update
  always_comb begin
    qadj = (dneg_q && yawq_q != '0) ? TWO_PI_Q29 - yawq_q : yawq_q;
    ysum = 34'($signed(acc_yaw_q)) + $signed({2'b0, qadj});
    yw   = (ysum >= PI_Q29) ? ysum - $signed({2'b0, TWO_PI_Q29}) : ysum;
  end

  // position steps: floor(ds * cs / 2^30)
  always_comb begin
    xp      = (sneg_q ^ cneg_q) ? 65'(-{1'b0, xmag_q}) : {1'b0, xmag_q};
    yp      = (sneg_q ^ sinneg_q) ? 65'(-{1'b0, ymag_q}) : {1'b0, ymag_q};
    xstep   = xp[64:30];
    ystep   = yp[64:30];
    acc_x_d = acc_x_q + {{5{xstep[34]}}, xstep};
    acc_y_d = acc_y_q + {{5{ystep[34]}}, ystep};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      ph_q        <= '0;
      j_q         <= '0;
      jump_q      <= 1'b0;
      cpm_q       <= CPM_RESET;
      cpr_q       <= CPR_RESET;
      ms_q        <= MS_RESET;
      cov_q       <= COV_RESET;
      last_r_q    <= '0;
      last_l_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_yaw_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_CPM:       cpm_q <= cfg_data_i[19:0];
          REG_CPR:       cpr_q <= cfg_data_i[19:0];
          REG_MAX_SPEED: ms_q  <= cfg_data_i[15:0];
          REG_COV:       cov_q <= cfg_data_i;
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_r_q <= in_if.right_count;
            last_l_q <= in_if.left_count;
            jump_q   <= 1'b0;
            k_q      <= '0;
            ph_q     <= '0;
            state_q  <= S_MUL;
          end
        end
        S_MUL: begin
          if (ph_q != 2'd2) begin
            ph_q <= ph_q + 2'd1;
          end else begin
            ph_q <= '0;
            k_q  <= k_q + 4'd1;
            if (k_q == 4'd3) begin
              if (el_q == '0 || jr_q || full[78:0] > {17'b0, plim_q}) begin
                jump_q  <= 1'b1;
                state_q <= S_DONE;
              end
            end else if (k_q == 4'd7) begin
              j_q     <= '0;
              state_q <= S_DIV_GO;
            end else if (k_q == 4'd9) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (j_q == 2'd3) begin
              state_q <= S_YAW;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_YAW: begin
          acc_yaw_q <= yw[31:0];
          state_q   <= S_COR_GO;
        end
        S_COR_GO: state_q <= S_COR_WAIT;
        S_COR_WAIT: begin
          if (cor_done) begin
            k_q     <= 4'd8;
            ph_q    <= '0;
            state_q <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (!jump_q) begin
              acc_x_q <= acc_x_d;
              acc_y_q <= acc_y_d;
            end
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      el_q    <= in_if.elapsed_us;
      mdr_q   <= dr[47] ? 48'(-dr) : dr;
      mdl_q   <= dl[47] ? 48'(-dl) : dl;
      msum_q  <= sum[48] ? 49'(-sum) : sum;
      mdiff_q <= diff[48] ? 49'(-diff) : diff;
      sneg_q  <= sum[48];
      dneg_q  <= diff[48];
    end
    if (state_q == S_MUL) begin
      if (ph_q == 2'd1) begin
        prod_lo_q <= mul_p;
      end else if (ph_q == 2'd2) begin
        unique case (k_q)
          4'd0: p1_q    <= full[39:0];
          4'd1: plim_q  <= full[61:0];
          4'd2: jr_q    <= full[78:0] > {17'b0, plim_q};
          4'd4: den_v_q <= full[43:0];
          4'd5: den_r_q <= full[43:0];
          4'd6: nv_q    <= full[62:0];
          4'd7: nr_q    <= full[62:0];
          4'd8: xmag_q  <= full[63:0];
          4'd9: ymag_q  <= full[63:0];
          default: ;
        endcase
      end
    end
    if (state_q == S_DIV_WAIT && div_done) begin
      unique case (j_q)
        2'd0: lv_q   <= sat_rate(sneg_q, ovf_v, div_q);
        2'd1: yr_q   <= sat_rate(dneg_q, ovf_r, div_q);
        2'd2: yawq_q <= div_q;
        2'd3: dq_q   <= ovf_d ? 32'hFFFF_FFFF : div_q;
      endcase
    end
    if (state_q == S_YAW) begin
      yaw_new_q <= yw[31:0];
    end
    if (state_q == S_COR_WAIT && cor_done) begin
      cneg_q   <= cor_cos[31];
      sinneg_q <= cor_sin[31];
      cmag_q   <= cor_cos[31] ? 32'(-cor_cos) : cor_cos;
      smag_q   <= cor_sin[31] ? 32'(-cor_sin) : cor_sin;
    end
    if (state_q == S_DONE && out_free) begin
      o_x_q    <= jump_q ? acc_x_q : acc_x_d;
      o_y_q    <= jump_q ? acc_y_q : acc_y_d;
      o_yaw_q  <= acc_yaw_q;
      o_lv_q   <= jump_q ? '0 : lv_q;
      o_yr_q   <= jump_q ? '0 : yr_q;
      o_cov_q  <= cov_q;
      o_jump_q <= jump_q;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.pos_x           = o_x_q;
  assign out_if.pos_y           = o_y_q;
  assign out_if.heading         = o_yaw_q;
  assign out_if.linear_velocity = o_lv_q;
  assign out_if.yaw_rate        = o_yr_q;
  assign out_if.covariance_out  = o_cov_q;
  assign out_if.jump_detected   = o_jump_q;

endmodule

### hdl/ddo_mul.sv
`timescale 1ns / 1ps
module ddo_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

### hdl/ddo_div.sv
`timescale 1ns / 1ps
module ddo_div import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  div_cmd_t           cmd_i,
  output logic               done_o,
  output logic [DIV_Q_W-1:0] q_o
);

  logic                  busy_q, done_q, mod_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIV_REM_W-1:0]  rem_q, den_q, rem_sh, rem_n;
  logic [DIV_BITS_W-1:0] bits_q;
  logic [DIV_Q_W-1:0]    q_q;
  logic [DIV_Q_W:0]      q2, q2_n;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q[DIV_REM_W-2:0], bits_q[DIV_BITS_W-1]};
    ge     = rem_sh >= den_q;
    rem_n  = ge ? rem_sh - den_q : rem_sh;
    q2     = {q_q, ge};
    // quotient kept modulo 2*pi in the heading pass
    if (mod_q && q2 >= {1'b0, TWO_PI_Q29}) begin
      q2_n = q2 - {1'b0, TWO_PI_Q29};
    end else begin
      q2_n = q2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= cmd_i.rem0;
      den_q  <= cmd_i.den;
      bits_q <= cmd_i.bits;
      mod_q  <= cmd_i.modular;
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_n;
      bits_q <= {bits_q[DIV_BITS_W-2:0], 1'b0};
      q_q    <= q2_n[DIV_Q_W-1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### hdl/ddo_cordic.sv
`timescale 1ns / 1ps
module ddo_cordic import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic                    busy_q, done_q, neg_q;
  logic [CORDIC_CNT_W-1:0] i_q;
  logic signed [33:0]      x_q, y_q, z_q, xs, ys, at, ang;
  logic signed [33:0]      x_n, y_n, z_n, z0;
  logic                    neg0;

  always_comb begin
    ang = 34'(angle_i);
    // fold into [-pi/2, pi/2], undo with a sign flip at the end
    if (ang > HALF_PI_Q29) begin
      z0 = ang - PI_Q29;
      neg0 = 1'b1;
    end else if (ang < -HALF_PI_Q29) begin
      z0 = ang + PI_Q29;
      neg0 = 1'b1;
    end else begin
      z0 = ang;
      neg0 = 1'b0;
    end
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = atan_q29(i_q);
    if (z_q >= 0) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + CORDIC_CNT_W'(1);
        if (i_q == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= z0;
      neg_q <= neg0;
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? 32'(-x_q) : x_q[31:0];
  assign sin_o  = neg_q ? 32'(-y_q) : y_q[31:0];

endmodule

### hdl/ddo_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddo_checker import ddo_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] heading_i,
  input logic signed [31:0] linear_velocity_i,
  input logic signed [31:0] yaw_rate_i,
  input logic               jump_detected_i
);

  // result held until the sink takes it
  `DDO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // one sample in flight: busy right after a transaction
  `DDO_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // held pose reports zero velocities
  `DDO_ASSERT_IMP(a_jump_zero_vel, clk_i, rst_ni, out_valid_i && jump_detected_i,
                  linear_velocity_i == 32'sd0 && yaw_rate_i == 32'sd0)
  // heading stays wrapped
  `DDO_ASSERT_IMP(a_heading_range, clk_i, rst_ni, out_valid_i,
                  34'(heading_i) < PI_Q29 && 34'(heading_i) >= -PI_Q29)

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .heading_i         (out_if.heading),
  .linear_velocity_i (out_if.linear_velocity),
  .yaw_rate_i        (out_if.yaw_rate),
  .jump_detected_i   (out_if.jump_detected)
);

### sim/tb.sv
`timescale 1ns / 1ps
module tb import ddo_pkg::*;;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] yaw_rate;
    logic        [31:0] cov;
    logic               jump;
  } odo_res_t;

  typedef struct {
    logic [47:0] right;
    logic [47:0] left;
    logic [23:0] el_us;
    bit          typed;
  } stim_row_t;

  localparam longint PI_L     = 64'sd1686629713;
  localparam longint HALF_PI_L = 64'sd843314856;
  localparam longint TWO_PI_L = 64'sd3373259426;
  localparam longint GAIN_L   = 64'sd652032874;
  localparam longint ATAN_TAB [10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                                       16771758, 8387925, 4194219, 2097141, 1048575};

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ddo_in_if  in_if ();
  ddo_out_if out_if ();

  diff_drive_odometry_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  // predictor state
  logic [19:0] cfg_cpm;
  logic [19:0] cfg_cpr;
  logic [15:0] cfg_max_speed;
  logic [31:0] cfg_cov;
  logic [47:0] last_right;
  logic [47:0] last_left;
  logic signed [39:0] acc_x;
  logic signed [39:0] acc_y;
  logic signed [31:0] acc_yaw;

  odo_res_t pose_q[$];
  int n_mismatch;
  int stall_left;
  bit no_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [127:0] mag128(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint sat_rate(longint n, logic [127:0] den);
    logic [127:0] q;
    q = mag128(n) * 128'd65536000000 / den;
    if (q > 128'h80000000) q = 128'h80000000;
    if (n < 0) return -longint'(q);
    return q > 128'h7FFFFFFF ? 64'sh7FFFFFFF : longint'(q);
  endfunction

  function automatic void rotate(longint ang, output longint c, output longint s);
    longint x, y, z, t, a;
    bit flip;
    x = GAIN_L;
    y = 0;
    z = ang;
    flip = 0;
    if (z > HALF_PI_L) begin
      z -= PI_L;
      flip = 1;
    end else if (z < -HALF_PI_L) begin
      z += PI_L;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      a = i < 10 ? ATAN_TAB[i] : (64'sd1 <<< (29 - i));
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= a;
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += a;
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit is_jump(logic [47:0] r, logic [47:0] l, logic [23:0] el);
    logic signed [47:0] tr, tl;
    logic [127:0] cpm, lim;
    tr = r - last_right;
    tl = l - last_left;
    cpm = cfg_cpm == 0 ? 1 : cfg_cpm;
    lim = 128'(cfg_max_speed) * el * cpm * 3 / 2000000000;
    return el == 0 || mag128(tr) > lim || mag128(tl) > lim;
  endfunction

  function automatic odo_res_t odometry_step(logic [47:0] r, logic [47:0] l, logic [23:0] el);
    odo_res_t res;
    logic signed [47:0] tr, tl;
    longint dr, dl, sum, diff, yaw, ds, c, s;
    logic [127:0] cpm, cpr, q, dq;
    bit jump;
    tr = r - last_right;
    tl = l - last_left;
    dr = tr;
    dl = tl;
    cpm = cfg_cpm == 0 ? 1 : cfg_cpm;
    cpr = cfg_cpr == 0 ? 1 : cfg_cpr;
    jump = is_jump(r, l, el);
    res.lin_vel = 0;
    res.yaw_rate = 0;
    last_right = r;
    last_left = l;
    if (!jump) begin
      sum = dr + dl;
      diff = dr - dl;
      res.lin_vel = 32'(sat_rate(sum, 2 * cpm * el));
      res.yaw_rate = 32'(sat_rate(diff, 2 * cpr * el));
      q = ((mag128(diff) << 29) / (2 * cpr)) % 128'(TWO_PI_L);
      if (diff < 0 && q != 0) q = 128'(TWO_PI_L) - q;
      yaw = longint'(acc_yaw) + longint'(q);
      if (yaw >= PI_L) yaw -= TWO_PI_L;
      acc_yaw = 32'(yaw);
      dq = (mag128(sum) << 16) / (2 * cpm);
      if (dq > 128'hFFFFFFFF) dq = 128'hFFFFFFFF;
      ds = sum < 0 ? -longint'(dq) : longint'(dq);
      rotate(yaw, c, s);
      acc_x = acc_x + 40'((ds * c) >>> 30);
      acc_y = acc_y + 40'((ds * s) >>> 30);
    end
    res.pos_x = acc_x;
    res.pos_y = acc_y;
    res.heading = acc_yaw;
    res.cov = cfg_cov;
    res.jump = jump;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    odo_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.pos_x, out_if.pos_y, out_if.heading, out_if.linear_velocity,
              out_if.yaw_rate, out_if.covariance_out, out_if.jump_detected};
      if (pose_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pose_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: x %0d/%0d y %0d/%0d hd %0d/%0d lv %0d/%0d yr %0d/%0d cov %0h/%0h jmp %0b/%0b",
                     want.pos_x, got.pos_x, want.pos_y, got.pos_y, want.heading, got.heading,
                     want.lin_vel, got.lin_vel, want.yaw_rate, got.yaw_rate,
                     want.cov, got.cov, want.jump, got.jump);
        end
      end
    end
  end

  // result-side backpressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (no_stall) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(39) == 0) stall_left <= $urandom_range(300, 60);
      else if ($urandom_range(3) == 0) stall_left <= $urandom_range(4, 1);
    end
  end

  task automatic wait_drained();
    while (pose_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_CPM:       cfg_cpm = data[19:0];
      REG_CPR:       cfg_cpr = data[19:0];
      REG_MAX_SPEED: cfg_max_speed = data[15:0];
      REG_COV:       cfg_cov = data;
    endcase
  endtask

  task automatic send_sample(logic [47:0] r, logic [47:0] l, logic [23:0] el, bit typed);
    odo_res_t want;
    int gap;
    in_if.valid <= 1'b1;
    in_if.right_count <= r;
    in_if.left_count <= l;
    in_if.elapsed_us <= el;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    want = odometry_step(r, l, el);
    // early rows: pose still at origin and every one of them is a jump
    if (typed) want = '{40'sd0, 40'sd0, 32'sd0, 32'sd0, 32'sd0, COV_RESET, 1'b1};
    pose_q = {pose_q, want};
    gap = no_stall ? 0 : ($urandom_range(9) == 0 ? $urandom_range(400, 30)
                                                 : $urandom_range(3) == 0 ? $urandom_range(3, 1) : 0);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_sample();
    logic [63:0] rnd;
    logic [127:0] cpm, lim;
    logic [63:0] dr, dl;
    logic [23:0] el;
    int kind;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0:       el = $urandom_range(16777215);
      1:       el = $urandom_range(20, 1);
      default: el = $urandom_range(200000, 100);
    endcase
    cpm = cfg_cpm == 0 ? 1 : cfg_cpm;
    lim = 128'(cfg_max_speed) * el * cpm * 3 / 2000000000;
    rnd = {$urandom, $urandom};
    dr = 64'(rnd % 64'(2 * lim + 1)) - 64'(lim);
    rnd = {$urandom, $urandom};
    dl = 64'(rnd % 64'(2 * lim + 1)) - 64'(lim);
    if (kind < 4) begin
      el = 0;
    end else if (kind < 8) begin
      dr = {$urandom, $urandom};
      dl = {$urandom, $urandom};
    end else if (kind < 12) begin
      dr = $urandom_range(1) ? 64'(lim + 1) : -64'(lim + 1);
    end else if (kind < 20) begin
      dr = 64'(lim);
      dl = $urandom_range(1) ? -64'(lim) : 64'(lim);
    end
    send_sample(last_right + dr[47:0], last_left + dl[47:0], el, 1'b0);
  endtask

  stim_row_t dir_rows [] = '{
    '{48'd0, 48'd0, 24'd0, 1'b1},
    '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 24'd0, 1'b1},
    '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 24'd1, 1'b1},
    '{48'd0, 48'd0, 24'hFFFFFF, 1'b1},
    '{48'd3000, 48'd3000, 24'd1000000, 1'b0},
    '{48'd0, 48'd0, 24'd1000000, 1'b0},
    '{48'd3000, -48'sd3000, 24'd1000000, 1'b0},
    '{48'd6000, -48'sd6000, 24'd1000000, 1'b0},
    '{48'd3000, -48'sd3000, 24'd1000000, 1'b0},
    '{48'd6001, -48'sd3000, 24'd1000000, 1'b0},
    '{48'd6001, -48'sd3000, 24'd1, 1'b0},
    '{48'd6101, -48'sd2900, 24'hFFFFFF, 1'b0},
    '{48'd6301, -48'sd2800, 24'd100000, 1'b0},
    '{48'd6201, -48'sd2700, 24'd100000, 1'b0}
  };

  initial begin
    n_mismatch = 0;
    stall_left = 0;
    no_stall = 0;
    cfg_cpm = CPM_RESET;
    cfg_cpr = CPR_RESET;
    cfg_max_speed = MS_RESET;
    cfg_cov = COV_RESET;
    last_right = '0;
    last_left = '0;
    acc_x = '0;
    acc_y = '0;
    acc_yaw = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CPM;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.right_count = '0;
    in_if.left_count = '0;
    in_if.elapsed_us = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].right, dir_rows[i].left, dir_rows[i].el_us, dir_rows[i].typed);

    for (int ph = 0; ph < 9; ph++) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      wait_drained();
      no_stall = (ph == 3);
      case (ph)
        0: ;
        1: begin
          write_reg(REG_CPM, 32'd1);
          write_reg(REG_CPR, 32'd1);
          write_reg(REG_MAX_SPEED, 32'd0);
          write_reg(REG_COV, 32'd0);
        end
        2: begin
          write_reg(REG_CPM, 32'd1000000);
          write_reg(REG_CPR, 32'd1000000);
          write_reg(REG_MAX_SPEED, 32'd65535);
          write_reg(REG_COV, 32'hFFFFFFFF);
        end
        3: begin
          // zero scale is taken as one; upper data bits are dropped
          write_reg(REG_CPM, 32'hFFF0_0000);
          write_reg(REG_CPR, 32'h0010_0000);
          write_reg(REG_MAX_SPEED, 32'h0001_FFFF);
        end
        4: begin
          write_reg(REG_CPM, 32'd1);
          write_reg(REG_CPR, 32'd1000000);
          write_reg(REG_MAX_SPEED, 32'd65535);
        end
        default: begin
          write_reg(REG_CPM, $urandom_range(1000000, 1));
          write_reg(REG_CPR, $urandom_range(1000000, 1));
          write_reg(REG_MAX_SPEED, $urandom_range(65535));
          write_reg(REG_COV, $urandom);
        end
      endcase
      for (int n = 0; n < 82; n++) begin
        // hold off once mid-phase until the pipeline is empty
        if (ph == 5 && n == 40) begin
          in_if.valid <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
        random_sample();
      end
    end
    in_if.valid <= 1'b0;
    no_stall = 0;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (n_mismatch == 0 && pose_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_if.sv
hdl/ddo_mul.sv
hdl/ddo_div.sv
hdl/ddo_cordic.sv
hdl/diff_drive_odometry_unit.sv
hdl/ddo_checker.sv
sim/tb.sv
